[design/fgn_pkg.sv]
// Shared constants, types and table functions for the fractal gradient noise block.
// Used by the channel interfaces, the octave lane and the top level.
// No dependencies.
package fgn_pkg;

    // Sizing
    localparam int MAX_OCTAVES     = 8;
    localparam int TRIG_TABLE_BITS = 10;
    localparam int QUARTER_BITS    = TRIG_TABLE_BITS - 2;
    localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;

    // Hash multipliers
    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048319325;

    // Quarter-wave sine polynomial, Q16
    localparam longint ONE_Q16 = 65536;
    localparam longint SIN_A   = 102944;
    localparam longint SIN_B   = 42048;
    localparam longint SIN_C   = 4640;

    // Datapath widths
    localparam int COORD_W  = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int OC_W     = 5;
    localparam int TRIG_W   = 18;
    localparam int LAYER_W  = 20;
    localparam int AMP_W    = 17;
    localparam int ASUM_W   = AMP_W + $clog2(MAX_OCTAVES);
    localparam int QUO_W    = LAYER_W - 1;
    localparam int TOT_W    = LAYER_W + ASUM_W + 1;
    localparam int U_W      = QUO_W + 2;
    localparam int T_FRAC_W = 16;
    localparam int NOISE_W  = 16;
    localparam int NUM_GRP  = (MAX_OCTAVES + 3) / 4;
    localparam int LANE_LAT = 12;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_SEED    = 3'd0,
        CFG_OCTAVE_COUNT = 3'd1,
        CFG_PERSISTENCE  = 3'd2,
        CFG_LACUNARITY   = 3'd3,
        CFG_STRETCH_LOW  = 3'd4,
        CFG_STRETCH_HIGH = 3'd5
    } t_cfg_idx;

    typedef logic [16:0] t_qsine_lut [QUARTER_SIZE+1];

    // Build the quarter-wave sine table at elaboration
    function automatic t_qsine_lut build_qsine();
        t_qsine_lut lut;
        longint z;
        longint z2;
        longint t;
        for (int k = 0; k <= QUARTER_SIZE; k++) begin
            z  = longint'(k) << (16 - QUARTER_BITS);
            z2 = (z * z) >> 16;
            t  = (SIN_C * z2) >> 16;
            t  = SIN_B - t;
            t  = (t * z2) >> 16;
            t  = SIN_A - t;
            lut[k] = 17'((z * t) >> 16);
        end
        return lut;
    endfunction

    localparam t_qsine_lut QSINE_LUT = build_qsine();

    // Full-turn sine entry from a table phase
    function automatic logic signed [TRIG_W-1:0] trig_lookup(
        input logic [TRIG_TABLE_BITS-1:0] p
    );
        logic [1:0]              quad;
        logic [QUARTER_BITS-1:0] k;
        logic [QUARTER_BITS:0]   idx;
        logic [TRIG_W-1:0]       s;
        quad = p[TRIG_TABLE_BITS-1 -: 2];
        k    = p[QUARTER_BITS-1:0];
        idx  = quad[0] ? ((QUARTER_BITS+1)'(QUARTER_SIZE) - {1'b0, k}) : {1'b0, k};
        s    = {1'b0, QSINE_LUT[idx]};
        return quad[1] ? -$signed(s) : $signed(s);
    endfunction

endpackage

[design/fgn_pt_if.sv]
// Input channel: one sample point per transaction.
// Depends on fgn_pkg for the coordinate width.
interface fgn_pt_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fgn_pkg::COORD_W-1:0]    coord_x;
    logic signed [fgn_pkg::COORD_W-1:0]    coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

[design/fgn_noise_if.sv]
// Output channel: one noise value per transaction.
// Depends on fgn_pkg for the result width.
interface fgn_noise_if;
    logic                           valid;
    logic                           ready;
    logic [fgn_pkg::NOISE_W-1:0]    noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

[design/fractal_gradient_noise_2d.sv]
// Top level of the fractal gradient noise block: configuration registers, octave lanes,
// weighting, normalizing divider and stretch smoothstep. Depends on fgn_pkg,
// fgn_pt_if, fgn_noise_if and fgn_octave.
//
// Usage
//   i_pt carries one signed Q16.16 (coord_x, coord_y) point per transaction; o_noise
//   returns one Q0.16 noise value per point, in order. A transaction completes when
//   valid and ready are both high at a rising edge.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while no point
//   is in flight. After each write, and after reset, i_pt.ready stays low while the
//   per-octave frequency and amplitude chains settle. A point passes the input
//   register, the octave lanes, the weighting and group-sum registers, the normalizing
//   divider, the smoothstep divider and the output stages. One point is taken every
//   cycle unless the output stalls or the chains are settling; all octaves run in
//   parallel lanes, so throughput does not depend on octave_count.
//   Reset (i_rst_n low, synchronous) empties the pipeline and loads register defaults.
//   When the receiver holds o_noise.ready low with a result waiting, the whole
//   pipeline holds and i_pt.ready drops in the same cycle; nothing is lost.
module fractal_gradient_noise_2d (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fgn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fgn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    fgn_pt_if.sink                             i_pt,
    fgn_noise_if.source                        o_noise
);

    localparam int M      = fgn_pkg::MAX_OCTAVES;
    localparam int SETTLE = M + 2;
    localparam int SET_W  = $clog2(SETTLE + 1);
    localparam int NST    = fgn_pkg::LANE_LAT + 7 + fgn_pkg::QUO_W + fgn_pkg::T_FRAC_W;

    // Configuration registers
    logic [31:0]      r_hash_seed;
    logic [3:0]       r_octave_count;
    logic [15:0]      r_persistence;
    logic [11:0]      r_lacunarity;
    logic [15:0]      r_stretch_low;
    logic [15:0]      r_stretch_high;
    logic [SET_W-1:0] r_settle;

    // Octave chains
    logic [31:0]                      r_freq [M];
    logic [fgn_pkg::AMP_W-1:0]        r_amp  [M];
    logic [fgn_pkg::ASUM_W-1:0]       r_acc  [M];
    logic [43:0]                      fq_prod [M];
    logic [32:0]                      am_prod [M];
    logic [fgn_pkg::OC_W-1:0]         oc;
    logic [M-1:0]                     lane_on;

    // Pipeline
    logic                             en;
    logic                             accept;
    logic [NST-1:0]                   r_vld;
    logic signed [fgn_pkg::COORD_W-1:0] r_s0_x, r_s0_y;
    logic signed [fgn_pkg::LAYER_W-1:0] layer [M];
    logic signed [37:0]               wt_prod [M];
    logic signed [fgn_pkg::TOT_W-1:0] r_wt  [M];
    logic signed [fgn_pkg::TOT_W-1:0] grp_sum [fgn_pkg::NUM_GRP];
    logic signed [fgn_pkg::TOT_W-1:0] r_grp [fgn_pkg::NUM_GRP];
    logic signed [fgn_pkg::TOT_W-1:0] tot;

    logic [fgn_pkg::TOT_W-1:0]        r_dv_rem [fgn_pkg::QUO_W+1];
    logic [fgn_pkg::QUO_W-1:0]        r_dv_q   [fgn_pkg::QUO_W+1];
    logic                             r_dv_neg [fgn_pkg::QUO_W+1];

    logic signed [fgn_pkg::QUO_W:0]   qs;
    logic signed [fgn_pkg::U_W-1:0]   usum, u, low_s, high_s, udiff;
    logic                             hard, lt_low, le_low, ge_high;

    logic [31:0]                      r_sd_rem [fgn_pkg::T_FRAC_W+1];
    logic [fgn_pkg::T_FRAC_W-1:0]     r_sd_q   [fgn_pkg::T_FRAC_W+1];
    logic                             r_sd_fix [fgn_pkg::T_FRAC_W+1];
    logic                             r_sd_one [fgn_pkg::T_FRAC_W+1];
    logic [15:0]                      span;

    logic [16:0]                      t_val;
    logic [33:0]                      t_sq;
    logic [16:0]                      r_sq_t, r_sq_tt;
    logic [34:0]                      ss_prod;
    logic [fgn_pkg::NOISE_W-1:0]      r_out;

    // Register writes and settle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_seed    <= '0;
            r_octave_count <= 4'd1;
            r_persistence  <= 16'd32768;
            r_lacunarity   <= 12'd512;
            r_stretch_low  <= '0;
            r_stretch_high <= 16'hFFFF;
            r_settle       <= SET_W'(SETTLE);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fgn_pkg::CFG_HASH_SEED:    r_hash_seed    <= i_cfg_data;
                    fgn_pkg::CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                    fgn_pkg::CFG_PERSISTENCE:  r_persistence  <= i_cfg_data[15:0];
                    fgn_pkg::CFG_LACUNARITY:   r_lacunarity   <= i_cfg_data[11:0];
                    fgn_pkg::CFG_STRETCH_LOW:  r_stretch_low  <= i_cfg_data[15:0];
                    fgn_pkg::CFG_STRETCH_HIGH: r_stretch_high <= i_cfg_data[15:0];
                    default: ;
                endcase
                r_settle <= SET_W'(SETTLE);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SET_W'(1);
            end
        end
    end

    // Clamp the octave count to 1..MAX_OCTAVES
    always_comb begin
        if (r_octave_count == 4'd0) begin
            oc = fgn_pkg::OC_W'(1);
        end else if (fgn_pkg::OC_W'(r_octave_count) > fgn_pkg::OC_W'(M)) begin
            oc = fgn_pkg::OC_W'(M);
        end else begin
            oc = fgn_pkg::OC_W'(r_octave_count);
        end
    end

    // Frequency, amplitude and amplitude-sum chains, one octave per register
    for (genvar i = 0; i < M; i++) begin : g_chain
        assign lane_on[i] = fgn_pkg::OC_W'(i) < oc;
        if (i == 0) begin : g_first
            assign fq_prod[i] = '0;
            assign am_prod[i] = '0;
            always_ff @(posedge i_clk) begin
                r_freq[i] <= 32'd256;
                r_amp[i]  <= fgn_pkg::AMP_W'(fgn_pkg::ONE_Q16);
                r_acc[i]  <= fgn_pkg::ASUM_W'(r_amp[i]);
            end
        end else begin : g_next
            assign fq_prod[i] = r_freq[i-1] * r_lacunarity;
            assign am_prod[i] = r_amp[i-1] * r_persistence;
            always_ff @(posedge i_clk) begin
                r_freq[i] <= (fq_prod[i][43:40] != 4'd0) ? 32'hFFFF_FFFF : fq_prod[i][39:8];
                r_amp[i]  <= am_prod[i][32:16];
                r_acc[i]  <= r_acc[i-1]
                             + (lane_on[i] ? fgn_pkg::ASUM_W'(r_amp[i]) : '0);
            end
        end
    end

    // Handshake: the pipeline advances unless a result is waiting and o_noise.ready is low
    assign en       = !r_vld[NST-1] || o_noise.ready;
    assign i_pt.ready = en && (r_settle == '0);
    assign accept   = i_pt.valid && i_pt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], accept};
        end
    end

    // Capture the point
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x <= i_pt.coord_x;
            r_s0_y <= i_pt.coord_y;
        end
    end

    // Octave lanes and amplitude weighting
    for (genvar i = 0; i < M; i++) begin : g_lane
        fgn_octave u_octave (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_x     (r_s0_x),
            .i_y     (r_s0_y),
            .i_freq  (r_freq[i]),
            .i_seed  (r_hash_seed),
            .o_layer (layer[i])
        );
        assign wt_prod[i] = layer[i] * $signed({1'b0, r_amp[i]});
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_wt[i] <= lane_on[i] ? fgn_pkg::TOT_W'(wt_prod[i]) : '0;
            end
        end
    end

    // Sum weighted layers in groups of four, then across groups
    always_comb begin
        for (int g = 0; g < fgn_pkg::NUM_GRP; g++) begin
            grp_sum[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (4 * g + j < M) begin
                    grp_sum[g] = grp_sum[g] + r_wt[4*g+j];
                end
            end
        end
    end

    always_comb begin
        tot = '0;
        for (int g = 0; g < fgn_pkg::NUM_GRP; g++) begin
            tot = tot + r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_grp       <= grp_sum;
            // floor division of a negative total works on ~total = -total - 1
            r_dv_rem[0] <= tot[fgn_pkg::TOT_W-1] ? ~tot : tot;
            r_dv_neg[0] <= tot[fgn_pkg::TOT_W-1];
            r_dv_q[0]   <= '0;
        end
    end

    // Normalizing divider: one quotient bit per stage
    for (genvar j = 0; j < fgn_pkg::QUO_W; j++) begin : g_div_norm
        localparam int K = fgn_pkg::QUO_W - 1 - j;
        logic [fgn_pkg::TOT_W-1:0] trial;
        logic                      ge;
        assign trial = fgn_pkg::TOT_W'(r_acc[M-1]) << K;
        assign ge    = r_dv_rem[j] >= trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[j+1] <= ge ? (r_dv_rem[j] - trial) : r_dv_rem[j];
                r_dv_q[j+1]   <= r_dv_q[j] | (fgn_pkg::QUO_W'(ge) << K);
                r_dv_neg[j+1] <= r_dv_neg[j];
            end
        end
    end

    // Map to 0..1 and decide the smoothstep case
    assign qs     = r_dv_neg[fgn_pkg::QUO_W] ? ~{1'b0, r_dv_q[fgn_pkg::QUO_W]}
                                             :  {1'b0, r_dv_q[fgn_pkg::QUO_W]};
    assign usum   = qs + fgn_pkg::U_W'(fgn_pkg::ONE_Q16);
    assign u      = usum >>> 1;
    assign low_s  = $signed(fgn_pkg::U_W'(r_stretch_low));
    assign high_s = $signed(fgn_pkg::U_W'(r_stretch_high));
    assign udiff  = u - low_s;
    assign hard   = r_stretch_high <= r_stretch_low;
    assign lt_low = u < low_s;
    assign le_low = u <= low_s;
    assign ge_high = u >= high_s;
    assign span   = r_stretch_high - r_stretch_low;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd_rem[0] <= {udiff[15:0], 16'd0};
            r_sd_q[0]   <= '0;
            r_sd_fix[0] <= hard || le_low || ge_high;
            r_sd_one[0] <= hard ? !lt_low : !le_low;
        end
    end

    // Smoothstep divider: one quotient bit per stage
    for (genvar j = 0; j < fgn_pkg::T_FRAC_W; j++) begin : g_div_step
        localparam int K = fgn_pkg::T_FRAC_W - 1 - j;
        logic [31:0] trial;
        logic        ge;
        assign trial = 32'(span) << K;
        assign ge    = r_sd_rem[j] >= trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd_rem[j+1] <= ge ? (r_sd_rem[j] - trial) : r_sd_rem[j];
                r_sd_q[j+1]   <= r_sd_q[j] | (fgn_pkg::T_FRAC_W'(ge) << K);
                r_sd_fix[j+1] <= r_sd_fix[j];
                r_sd_one[j+1] <= r_sd_one[j];
            end
        end
    end

    // Smoothstep polynomial t^2 (3 - 2t), saturate full scale
    always_comb begin
        if (r_sd_fix[fgn_pkg::T_FRAC_W]) begin
            t_val = r_sd_one[fgn_pkg::T_FRAC_W] ? 17'(fgn_pkg::ONE_Q16) : 17'd0;
        end else begin
            t_val = {1'b0, r_sd_q[fgn_pkg::T_FRAC_W]};
        end
    end
    assign t_sq    = t_val * t_val;
    assign ss_prod = r_sq_tt * (18'd196608 - {r_sq_t, 1'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_t  <= t_val;
            r_sq_tt <= t_sq[32:16];
            r_out   <= (ss_prod[34:16] > 19'd65535) ? 16'hFFFF : ss_prod[31:16];
        end
    end

    assign o_noise.valid       = r_vld[NST-1];
    assign o_noise.noise_value = r_out;

`ifndef SYNTHESIS
    // A valid item one stage from the end reaches the output when the pipe moves
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[NST-2] |=> o_noise.valid)
        else $error("pipeline lost a transaction at the output stage");

    // A stalled result must block new input
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_noise.valid && !o_noise.ready |-> !i_pt.ready)
        else $error("input accepted while output stalled");

    // Normalizing divisor is settled and at least one when points may enter
    a_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle == '0 |-> r_acc[M-1] >= fgn_pkg::ASUM_W'(fgn_pkg::ONE_Q16))
        else $error("amplitude sum below one after settling");
`endif

endmodule

[design/fgn_octave.sv]
// One noise octave: scale, corner hashing, gradient lookup, dot products and fade blend.
// Twelve register stages, all advanced by one enable. Depends on fgn_pkg.
module fgn_octave (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [fgn_pkg::COORD_W-1:0]   i_x,
    input  logic signed [fgn_pkg::COORD_W-1:0]   i_y,
    input  logic [31:0]                          i_freq,
    input  logic [31:0]                          i_seed,
    output logic signed [fgn_pkg::LAYER_W-1:0]   o_layer
);

    // Stage registers
    logic [31:0] r1_ix, r1_iy;
    logic [15:0] r1_fx, r1_fy;
    logic [31:0] r2_ax [2];
    logic [31:0] r2_by [2];
    logic [15:0] r2_fx, r2_fy, r2_w2x, r2_w2y;
    logic [31:0] r3_ma [2];
    logic [31:0] r3_by [2];
    logic [15:0] r3_fx, r3_fy;
    logic [16:0] r3_wx, r3_wy;
    logic [31:0] r4_ma [2];
    logic [31:0] r4_mb [4];
    logic [15:0] r4_fx, r4_fy;
    logic [16:0] r4_wx, r4_wy;
    logic [31:0] r5_h [4];
    logic [15:0] r5_fx, r5_fy;
    logic [16:0] r5_wx, r5_wy;
    logic signed [fgn_pkg::TRIG_W-1:0] r6_gx [4];
    logic signed [fgn_pkg::TRIG_W-1:0] r6_gy [4];
    logic [15:0] r6_fx, r6_fy;
    logic [16:0] r6_wx, r6_wy;
    logic signed [34:0] r7_px [4];
    logic signed [34:0] r7_py [4];
    logic [16:0] r7_wx, r7_wy;
    logic signed [fgn_pkg::LAYER_W-1:0] r8_n [4];
    logic [16:0] r8_wx, r8_wy;
    logic signed [38:0] r9_p0, r9_p1;
    logic signed [fgn_pkg::LAYER_W-1:0] r9_n00, r9_n01;
    logic [16:0] r9_wy;
    logic signed [fgn_pkg::LAYER_W-1:0] r10_b0, r10_b1;
    logic [16:0] r10_wy;
    logic signed [38:0] r11_p;
    logic signed [fgn_pkg::LAYER_W-1:0] r11_b0;
    logic signed [fgn_pkg::LAYER_W-1:0] r12_layer;

    // Combinational values between stages
    logic signed [64:0] prod_x, prod_y;
    logic [31:0] sq_x, sq_y;
    logic [33:0] fd_x, fd_y;
    logic [31:0] n_ma [2];
    logic [31:0] n_mb [4];
    logic [31:0] n_h [4];
    logic signed [fgn_pkg::TRIG_W-1:0] n_gx [4];
    logic signed [fgn_pkg::TRIG_W-1:0] n_gy [4];
    logic signed [34:0] n_px [4];
    logic signed [34:0] n_py [4];
    logic signed [35:0] n_dot [4];
    logic signed [38:0] n_p0, n_p1, n_p;
    logic signed [22:0] n_b0, n_b1, n_layer;

    // Scale the point by the octave frequency
    assign prod_x = i_x * $signed({1'b0, i_freq});
    assign prod_y = i_y * $signed({1'b0, i_freq});

    // Fade polynomial (3 - 2w) w^2
    assign sq_x = r1_fx * r1_fx;
    assign sq_y = r1_fy * r1_fy;
    assign fd_x = (18'd196608 - {1'b0, r2_fx, 1'b0}) * r2_w2x;
    assign fd_y = (18'd196608 - {1'b0, r2_fy, 1'b0}) * r2_w2y;

    // Corner hashing, gradients and dot products
    for (genvar k = 0; k < 2; k++) begin : g_col
        assign n_ma[k] = r2_ax[k] * fgn_pkg::HASH_MUL_A;
    end

    for (genvar c = 0; c < 4; c++) begin : g_corner
        localparam int  KX = c % 2;
        localparam int  KY = c / 2;
        localparam bit  BX = (KX == 1);
        localparam bit  BY = (KY == 1);
        logic [fgn_pkg::TRIG_TABLE_BITS-1:0] phase;

        assign n_mb[c] = (r3_by[KY] ^ {r3_ma[KX][15:0], r3_ma[KX][31:16]})
                         * fgn_pkg::HASH_MUL_B;
        assign n_h[c]  = (r4_ma[KX] ^ {r4_mb[c][15:0], r4_mb[c][31:16]})
                         * fgn_pkg::HASH_MUL_C;
        assign phase   = r5_h[c][30 -: fgn_pkg::TRIG_TABLE_BITS];
        assign n_gx[c] = fgn_pkg::trig_lookup(phase);
        assign n_gy[c] = fgn_pkg::trig_lookup(
            phase + fgn_pkg::TRIG_TABLE_BITS'(fgn_pkg::QUARTER_SIZE));
        assign n_px[c] = $signed({BX, r6_fx}) * r6_gx[c];
        assign n_py[c] = $signed({BY, r6_fy}) * r6_gy[c];
        assign n_dot[c] = r7_px[c] + r7_py[c];
    end

    // Blends along x, then y
    assign n_p0    = (r8_n[1] - r8_n[0]) * $signed({1'b0, r8_wx});
    assign n_p1    = (r8_n[3] - r8_n[2]) * $signed({1'b0, r8_wx});
    assign n_b0    = r9_n00 + $signed(r9_p0[38:16]);
    assign n_b1    = r9_n01 + $signed(r9_p1[38:16]);
    assign n_p     = (r10_b1 - r10_b0) * $signed({1'b0, r10_wy});
    assign n_layer = r11_b0 + $signed(r11_p[38:16]);

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ix <= prod_x[55:24];
            r1_iy <= prod_y[55:24];
            r1_fx <= prod_x[23:8];
            r1_fy <= prod_y[23:8];

            r2_ax[0] <= r1_ix + i_seed;
            r2_ax[1] <= r1_ix + 32'd1 + i_seed;
            r2_by[0] <= r1_iy + i_seed;
            r2_by[1] <= r1_iy + 32'd1 + i_seed;
            r2_fx    <= r1_fx;
            r2_fy    <= r1_fy;
            r2_w2x   <= sq_x[31:16];
            r2_w2y   <= sq_y[31:16];

            r3_ma <= n_ma;
            r3_by <= r2_by;
            r3_fx <= r2_fx;
            r3_fy <= r2_fy;
            r3_wx <= fd_x[32:16];
            r3_wy <= fd_y[32:16];

            r4_ma <= r3_ma;
            r4_mb <= n_mb;
            r4_fx <= r3_fx;
            r4_fy <= r3_fy;
            r4_wx <= r3_wx;
            r4_wy <= r3_wy;

            r5_h  <= n_h;
            r5_fx <= r4_fx;
            r5_fy <= r4_fy;
            r5_wx <= r4_wx;
            r5_wy <= r4_wy;

            r6_gx <= n_gx;
            r6_gy <= n_gy;
            r6_fx <= r5_fx;
            r6_fy <= r5_fy;
            r6_wx <= r5_wx;
            r6_wy <= r5_wy;

            r7_px <= n_px;
            r7_py <= n_py;
            r7_wx <= r6_wx;
            r7_wy <= r6_wy;

            for (int c = 0; c < 4; c++) begin
                r8_n[c] <= n_dot[c][35:16];
            end
            r8_wx <= r7_wx;
            r8_wy <= r7_wy;

            r9_p0  <= n_p0;
            r9_p1  <= n_p1;
            r9_n00 <= r8_n[0];
            r9_n01 <= r8_n[2];
            r9_wy  <= r8_wy;

            r10_b0 <= n_b0[fgn_pkg::LAYER_W-1:0];
            r10_b1 <= n_b1[fgn_pkg::LAYER_W-1:0];
            r10_wy <= r9_wy;

            r11_p  <= n_p;
            r11_b0 <= r10_b0;

            r12_layer <= n_layer[fgn_pkg::LAYER_W-1:0];
        end
    end

    assign o_layer = r12_layer;

endmodule
